@@ hdl/s2ow_pkg.sv @@
// s2ow_pkg: shared types and codes for the serial to 1-wire bridge
// no dependencies
`default_nettype none
package s2ow_pkg;
  localparam int ParamEntries = 8;

  typedef enum logic [1:0] {OP_HOST = 2'd0, OP_SLOT = 2'd1, OP_RST = 2'd2, OP_NONE = 2'd3} op_t;
  typedef enum logic [1:0] {K_SLOT = 2'd0, K_RESET = 2'd1, K_REPLY = 2'd2, K_SPARE = 2'd3} kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_val;
    logic       slot_sample;
    logic       rst_first;
    logic       rst_second;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       slot_bit;
    logic [7:0] reply_byte;
    logic       last;
  } result_t;

  localparam logic [7:0] CmdDataMode = 8'hE1;
  localparam logic [7:0] CmdCheck    = 8'hE3;
  localparam logic [7:0] CmdIgnore   = 8'hF1;
  localparam logic [7:0] CmdMask     = 8'hE1;
  localparam logic [7:0] CmdBit      = 8'h81;
  localparam logic [7:0] CmdSearch   = 8'hA1;
  localparam logic [7:0] CmdReset    = 8'hC1;
  localparam logic [7:0] CmdPulse    = 8'hE1;
  localparam logic [7:0] BitKeep     = 8'h9C;
  localparam logic [7:0] BitTail     = 8'hEC;
  localparam logic [7:0] RstTail     = 8'hCC;
  localparam logic [7:0] PulseKeep   = 8'h1C;
  localparam logic [7:0] AddrMask    = 8'h70;
  localparam logic [7:0] ValMask     = 8'h0E;
endpackage
`default_nettype wire

@@ hdl/s2ow_fifo.sv @@
// s2ow_fifo: small synchronous queue used between the front and back ends
// and at the output; depends on nothing
`default_nettype none
module s2ow_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);
  localparam int Aw = $clog2(Depth);
  logic [Width-1:0] mem [Depth];
  logic [Aw-1:0] wptr, rptr;
  logic [Aw:0] count;
  logic do_push, do_pop;

  assign full    = (count == (Aw+1)'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == Aw'(Depth-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == Aw'(Depth-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

@@ hdl/s2ow_back.sv @@
// s2ow_back: executes items, holds the bridge state and emits up to two results
// depends on s2ow_pkg
`default_nettype none
module s2ow_back
  import s2ow_pkg::*;
#(
  parameter int ParamN = ParamEntries
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  item_t        in_item,
  output logic         in_take,
  output logic         out_push,
  output result_t      out_res,
  input  wire logic    out_full
);
  localparam int Iw = $clog2(ParamN);
  typedef enum logic [1:0] {M_CMD = 2'd0, M_DATA = 2'd1, M_CHECK = 2'd2, M_SPARE = 2'd3} mode_t;
  typedef enum logic [1:0] {P_IDLE = 2'd0, P_BYTE = 2'd1, P_BIT = 2'd2, P_RESET = 2'd3} pend_t;

  mode_t mode, mode_next;
  pend_t pend, pend_next;
  logic search, search_next;
  logic [2:0] ptab [ParamN];
  logic [7:0] held, held_next, acc, acc_next;
  logic [3:0] sidx, sidx_next;
  logic [1:0] frb, frb_next;
  logic pw_en;
  logic [Iw-1:0] pw_addr;
  logic [2:0] pw_val;
  // second result of a two-result item waits here
  logic hold_v;
  result_t hold_r, hold_r_next;
  logic hold_set;
  result_t r0;
  logic r0_v;

  // slot position within its triplet (slot index mod 3)
  function automatic logic [1:0] trip_phase(logic [3:0] si);
    logic [1:0] p;
    case (si)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: p = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13: p = 2'd1;
      default: p = 2'd2;
    endcase
    return p;
  endfunction

  // reply bit offset of the triplet, twice the triplet number wrapped to 0..6
  function automatic logic [2:0] trip_shift(logic [3:0] si);
    logic [2:0] t;
    case (si)
      4'd3, 4'd4, 4'd5, 4'd15: t = 3'd2;
      4'd6, 4'd7, 4'd8: t = 3'd4;
      4'd9, 4'd10, 4'd11: t = 3'd6;
      default: t = 3'd0;
    endcase
    return t;
  endfunction

  function automatic logic dbit(logic s, logic [3:0] si, logic [1:0] f, logic [7:0] h);
    logic [2:0] ti;
    logic [1:0] ph;
    ti = trip_shift(si);
    ph = trip_phase(si);
    if (!s) return h[si[2:0]];
    if (ph < 2'd2) return 1'b1;
    if (!(f[0] | f[1])) return h[ti + 3'd1];
    if (!(f[0] & f[1])) return f[0];
    return 1'b1;
  endfunction

  assign in_take = in_valid && !out_full && !hold_v;

  always_comb begin
    logic [7:0] c, r;
    logic got;
    logic [1:0] ph;
    logic [3:0] ni;
    logic [1:0] d;
    logic [2:0] ti;
    logic cmd;
    mode_next = mode; pend_next = pend; search_next = search;
    held_next = held; acc_next = acc; sidx_next = sidx; frb_next = frb;
    pw_en = 1'b0; pw_addr = '0; pw_val = '0;
    r0 = '0; r0_v = 1'b0; hold_set = 1'b0; hold_r_next = '0;
    c = in_item.byte_val; r = '0; got = 1'b0; ph = '0; ni = '0; d = '0; ti = '0;
    cmd = 1'b0;
    r0.last = 1'b1;
    if (in_take) begin
      case (op_t'(in_item.op))
        OP_HOST: begin
          if (pend == P_IDLE) begin
            if (mode == M_DATA) begin
              if (c == CmdCheck) mode_next = M_CHECK;
              else begin
                held_next = c; sidx_next = '0; acc_next = '0; frb_next = '0;
                pend_next = P_BYTE; r0_v = 1'b1; r0.kind = K_SLOT;
                r0.slot_bit = dbit(search, 4'd0, 2'd0, c);
              end
            end else if (mode == M_CHECK) begin
              if (c == CmdCheck) begin
                mode_next = M_DATA;
                held_next = c; sidx_next = '0; acc_next = '0; frb_next = '0;
                pend_next = P_BYTE; r0_v = 1'b1; r0.kind = K_SLOT;
                r0.slot_bit = dbit(search, 4'd0, 2'd0, c);
              end else begin
                mode_next = M_CMD; cmd = 1'b1;
              end
            end else begin
              mode_next = M_CMD;
              if (c == CmdDataMode) mode_next = M_DATA;
              else if (c != CmdCheck && c != CmdIgnore) cmd = 1'b1;
            end
          end
          if (cmd) begin
            if (c[7]) begin
              if ((c & CmdMask) == CmdBit) begin
                held_next = c; pend_next = P_BIT; r0_v = 1'b1;
                r0.kind = K_SLOT; r0.slot_bit = c[4];
              end else if ((c & CmdMask) == CmdSearch) begin
                search_next = c[4];
              end else if ((c & CmdMask) == CmdReset) begin
                pend_next = P_RESET; r0_v = 1'b1; r0.kind = K_RESET;
              end else if ((c & CmdMask) == CmdPulse) begin
                r0_v = 1'b1; r0.kind = K_REPLY; r0.reply_byte = (c & PulseKeep) | 8'hE0;
              end
            end else if ((c & AddrMask) != 8'h00) begin
              pw_en = 1'b1; pw_addr = Iw'(c[6:4]); pw_val = c[3:1];
              r0_v = 1'b1; r0.kind = K_REPLY; r0.reply_byte = c & 8'hFE;
            end else begin
              r0_v = 1'b1; r0.kind = K_REPLY;
              r0.reply_byte = (c & 8'hF0) | {4'd0, ptab[Iw'(c[3:1])], 1'b0};
            end
          end
        end
        OP_SLOT: begin
          if (pend == P_BIT) begin
            r = {6'd0, {2{held[4] & in_item.slot_sample}}} | (held & BitKeep);
            pend_next = P_IDLE; r0_v = 1'b1; r0.kind = K_REPLY; r0.reply_byte = r;
            if (held[1]) begin
              r0.last = 1'b0; hold_set = 1'b1;
              hold_r_next.kind = K_REPLY; hold_r_next.last = 1'b1;
              hold_r_next.reply_byte = (r & 8'h03) | BitTail;
            end
          end else if (pend == P_BYTE) begin
            got = dbit(search, sidx, frb, held) & in_item.slot_sample;
            ni = sidx + 4'd1;
            sidx_next = ni;
            r0_v = 1'b1;
            if (search) begin
              ph = trip_phase(sidx);
              ti = trip_shift(sidx);
              if (ph == 2'd0) frb_next = {1'b0, got};
              else if (ph == 2'd1) frb_next = {got, frb[0]};
              else begin
                d = {got, ~(frb[0] ^ frb[1])};
                acc_next = acc | ({6'd0, d} << ti);
              end
              if (ni >= 4'd12) begin
                pend_next = P_IDLE; r0.kind = K_REPLY; r0.reply_byte = acc_next;
              end else begin
                r0.kind = K_SLOT; r0.slot_bit = dbit(1'b1, ni, frb_next, held);
              end
            end else begin
              acc_next = acc | ({7'd0, got} << sidx[2:0]);
              if (ni >= 4'd8) begin
                pend_next = P_IDLE; r0.kind = K_REPLY; r0.reply_byte = acc_next;
              end else begin
                r0.kind = K_SLOT; r0.slot_bit = dbit(1'b0, ni, frb, held);
              end
            end
          end
        end
        OP_RST: begin
          if (pend == P_RESET) begin
            pend_next = P_IDLE; r0_v = 1'b1; r0.kind = K_REPLY;
            r0.reply_byte = {6'd0, in_item.rst_second, in_item.rst_first} | RstTail;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_push = hold_v ? 1'b1 : r0_v;
  assign out_res  = hold_v ? hold_r : r0;

  always_ff @(posedge clk) begin
    if (pw_en && pw_addr != '0) ptab[pw_addr] <= pw_val;
    if (hold_set) hold_r <= hold_r_next;
    if (rst) begin
      for (int i = 0; i < ParamN; i++) ptab[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_CMD; pend <= P_IDLE; search <= 1'b0; held <= '0; acc <= '0;
      sidx <= '0; frb <= '0; hold_v <= 1'b0;
    end else begin
      mode <= mode_next; pend <= pend_next; search <= search_next; held <= held_next;
      acc <= acc_next; sidx <= sidx_next; frb <= frb_next;
      if (hold_set) hold_v <= 1'b1;
      else if (hold_v && !out_full) hold_v <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hdl/serial_to_onewire_bridge_top.sv @@
// serial_to_onewire_bridge_top: front queue, execution back end and result queue
// depends on s2ow_pkg, s2ow_fifo, s2ow_back
//
// usage
//   input channel: push/full carries one beat per host byte or returned bus sample
//   (operation selects which); output channel: empty/pop presents result beats
//   in order (kind, slot_bit, reply_byte, last)
// data path
//   an accepted beat is written into the 4-entry front queue, executed by the
//   combinational back end, and its first result is written into the result
//   queue, whose head drives the output ports and can then be popped
// throughput
//   one input beat per cycle while full is low; the back end executes one
//   beat per cycle while the result queue has room and no second bit reply waits
// reset
//   rst clears both queues, mode to command, search off, the parameter table to
//   zero and no bus operation pending
// stall
//   when pop stays low the result queue fills, the back end pauses, then the
//   input queue fills and full rises; nothing is lost
`default_nettype none
module serial_to_onewire_bridge_top
  import s2ow_pkg::*;
#(
  parameter int ParamN = ParamEntries
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] host_byte,
  input  wire logic       slot_sample,
  input  wire logic       reset_first_sample,
  input  wire logic       reset_second_sample,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      kind,
  output logic            slot_bit,
  output logic [7:0]      reply_byte,
  output logic            last
);
  item_t   in_w, q_item;
  result_t res_w, out_w;
  logic q_empty, take, rpush, rfull;

  assign in_w = '{op: operation, byte_val: host_byte, slot_sample: slot_sample,
                  rst_first: reset_first_sample, rst_second: reset_second_sample};

  // front queue decouples the host side from execution
  s2ow_fifo #(.Width($bits(item_t)), .Depth(4)) u_front (
    .clk(clk), .rst(rst), .push(push), .wdata(in_w), .full(full),
    .pop(take), .rdata(q_item), .empty(q_empty)
  );

  s2ow_back #(.ParamN(ParamN)) u_back (
    .clk(clk), .rst(rst), .in_valid(!q_empty), .in_item(q_item), .in_take(take),
    .out_push(rpush), .out_res(res_w), .out_full(rfull)
  );

  // result queue
  s2ow_fifo #(.Width($bits(result_t)), .Depth(4)) u_out (
    .clk(clk), .rst(rst), .push(rpush), .wdata(res_w), .full(rfull),
    .pop(pop), .rdata(out_w), .empty(empty)
  );

  assign kind       = out_w.kind;
  assign slot_bit   = out_w.slot_bit;
  assign reply_byte = out_w.reply_byte;
  assign last       = out_w.last;
endmodule
`default_nettype wire

@@ hdl/s2ow_checker.sv @@
// s2ow_checker: port-level checks on the bridge, bound to the top level
// depends on s2ow_pkg
`default_nettype none
module s2ow_checker
  import s2ow_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [1:0] kind,
  input wire logic       slot_bit,
  input wire logic [7:0] reply_byte,
  input wire logic       last
);
  a_kind: assert property (@(posedge clk) disable iff (rst) !empty |-> kind != K_SPARE)
    else $error("bad kind");
  a_req0: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_REPLY) |-> (reply_byte == 8'h00 && last))
    else $error("request fields");
  a_rep0: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != K_SLOT) |-> !slot_bit)
    else $error("slot bit in non-slot");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(reply_byte) && $stable(kind)))
    else $error("result not held");
endmodule

bind serial_to_onewire_bridge_top s2ow_checker u_chk (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .kind(kind),
  .slot_bit(slot_bit), .reply_byte(reply_byte), .last(last)
);
`default_nettype wire

@@ dv/tb_serial_to_onewire_bridge_top.sv @@
// tb_serial_to_onewire_bridge_top: self-checking bench for the serial to 1-wire bridge
// depends on s2ow_pkg and serial_to_onewire_bridge_top; directed table then random beats
`timescale 1ns / 1ps
`default_nettype none
module tb_serial_to_onewire_bridge_top;
  import s2ow_pkg::*;

  // bridge state kept by the bench
  localparam logic [1:0] ST_CMD = 2'd0, ST_DATA = 2'd1, ST_ESC = 2'd2;
  localparam logic [1:0] BUS_IDLE = 2'd0, BUS_BYTE = 2'd1, BUS_BIT = 2'd2, BUS_RST = 2'd3;

  logic clk, rst;
  logic push, pop;
  logic full, empty;
  logic [1:0] operation;
  logic [7:0] host_byte;
  logic slot_sample, reset_first_sample, reset_second_sample;
  logic [1:0] kind;
  logic slot_bit, last;
  logic [7:0] reply_byte;

  serial_to_onewire_bridge_top DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .host_byte(host_byte), .slot_sample(slot_sample),
    .reset_first_sample(reset_first_sample), .reset_second_sample(reset_second_sample),
    .empty(empty), .pop(pop), .kind(kind), .slot_bit(slot_bit),
    .reply_byte(reply_byte), .last(last)
  );

  result_t    pending_results[$];
  int         fail_count;
  int         beats_sent;
  int         results_seen;

  // predictor state
  logic [1:0] br_mode;
  logic       br_search;
  logic [2:0] br_params[8];
  logic [1:0] br_bus;
  logic [7:0] br_held;
  logic [3:0] br_slot;
  logic [7:0] br_accum;
  logic [1:0] br_reads;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // give up well beyond the slowest legal run
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  function automatic result_t mk(logic [1:0] k, logic b, logic [7:0] y, logic l);
    result_t r;
    r.kind = k; r.slot_bit = b; r.reply_byte = y; r.last = l;
    return r;
  endfunction

  function automatic logic triplet_dir();
    logic [2:0] i;
    i = 3'((br_slot / 3) * 2) & 3'd6;
    if (br_reads == 2'b00) return br_held[i + 3'd1];
    if (br_reads != 2'b11) return br_reads[0];
    return 1'b1;
  endfunction

  function automatic logic next_write_bit();
    if (br_search) return (br_slot % 3 < 2) ? 1'b1 : triplet_dir();
    return br_held[br_slot[2:0]];
  endfunction

  task automatic begin_byte(logic [7:0] c);
    br_held = c; br_slot = 0; br_accum = 0; br_reads = 0; br_bus = BUS_BYTE;
    pending_results.push_back(mk(K_SLOT, next_write_bit(), 8'h00, 1'b1));
  endtask

  task automatic run_command(logic [7:0] c);
    logic [2:0] v;
    if (c[7]) begin
      case (c & CmdMask)
        CmdBit: begin
          br_held = c; br_bus = BUS_BIT;
          pending_results.push_back(mk(K_SLOT, c[4], 8'h00, 1'b1));
        end
        CmdSearch: br_search = c[4];
        CmdReset: begin
          br_bus = BUS_RST;
          pending_results.push_back(mk(K_RESET, 1'b0, 8'h00, 1'b1));
        end
        CmdPulse: pending_results.push_back(mk(K_REPLY, 1'b0, (c & PulseKeep) | 8'hE0, 1'b1));
        default: ;
      endcase
    end else if ((c & AddrMask) != 0) begin
      br_params[c[6:4]] = c[3:1];
      pending_results.push_back(mk(K_REPLY, 1'b0, c & 8'hFE, 1'b1));
    end else begin
      v = br_params[c[3:1]];
      pending_results.push_back(mk(K_REPLY, 1'b0, (c & 8'hF0) | {4'd0, v, 1'b0}, 1'b1));
    end
  endtask

  // work out the results of one accepted beat
  task automatic predict_beat(item_t it);
    logic got, dirb;
    logic [7:0] r;
    logic [2:0] i;
    case (it.op)
      OP_HOST: if (br_bus == BUS_IDLE) begin
        if (br_mode == ST_DATA) begin
          if (it.byte_val == CmdCheck) br_mode = ST_ESC;
          else begin_byte(it.byte_val);
        end else if (br_mode == ST_ESC) begin
          if (it.byte_val == CmdCheck) begin
            br_mode = ST_DATA; begin_byte(it.byte_val);
          end else begin
            br_mode = ST_CMD; run_command(it.byte_val);
          end
        end else begin
          br_mode = ST_CMD;
          if (it.byte_val == CmdDataMode) br_mode = ST_DATA;
          else if (it.byte_val != CmdCheck && it.byte_val != CmdIgnore)
            run_command(it.byte_val);
        end
      end
      OP_SLOT: begin
        if (br_bus == BUS_BIT) begin
          r = {6'd0, {2{br_held[4] & it.slot_sample}}} | (br_held & BitKeep);
          br_bus = BUS_IDLE;
          if (br_held[1]) begin
            pending_results.push_back(mk(K_REPLY, 1'b0, r, 1'b0));
            pending_results.push_back(mk(K_REPLY, 1'b0, (r & 8'h03) | BitTail, 1'b1));
          end else pending_results.push_back(mk(K_REPLY, 1'b0, r, 1'b1));
        end else if (br_bus == BUS_BYTE) begin
          got = next_write_bit() & it.slot_sample;
          if (br_search) begin
            if (br_slot % 3 == 0) br_reads = {1'b0, got};
            else if (br_slot % 3 == 1) br_reads[1] = got;
            else begin
              dirb = ~(br_reads[0] ^ br_reads[1]);
              i = 3'((br_slot / 3) * 2) & 3'd6;
              br_accum = br_accum | ({6'd0, got, dirb} << i);
            end
            br_slot = br_slot + 4'd1;
            if (br_slot >= 12) begin
              br_bus = BUS_IDLE;
              pending_results.push_back(mk(K_REPLY, 1'b0, br_accum, 1'b1));
            end else pending_results.push_back(mk(K_SLOT, next_write_bit(), 8'h00, 1'b1));
          end else begin
            br_accum[br_slot[2:0]] = br_accum[br_slot[2:0]] | got;
            br_slot = br_slot + 4'd1;
            if (br_slot >= 8) begin
              br_bus = BUS_IDLE;
              pending_results.push_back(mk(K_REPLY, 1'b0, br_accum, 1'b1));
            end else pending_results.push_back(mk(K_SLOT, next_write_bit(), 8'h00, 1'b1));
          end
        end
      end
      OP_RST: if (br_bus == BUS_RST) begin
        br_bus = BUS_IDLE;
        pending_results.push_back(mk(K_REPLY, 1'b0,
            {6'b110011, it.rst_second, it.rst_first}, 1'b1));
      end
      default: ;
    endcase
  endtask

  // one beat into the input queue; predictor runs at acceptance
  // push stays high across back-to-back beats and drops only before an idle gap
  task automatic send_beat(logic [1:0] op, logic [7:0] b, logic s, logic f, logic g);
    item_t it;
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1; operation <= op; host_byte <= b;
    slot_sample <= s; reset_first_sample <= f; reset_second_sample <= g;
    @(posedge clk);
    while (full) @(posedge clk);
    it.op = op; it.byte_val = b; it.slot_sample = s; it.rst_first = f; it.rst_second = g;
    predict_beat(it);
    beats_sent++;
  endtask

  // answer the bus request the bridge is waiting for, if any
  task automatic answer_bus();
    if (br_bus == BUS_RST)
      send_beat(OP_RST, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    else if (br_bus != BUS_IDLE)
      send_beat(OP_SLOT, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // result side: random pop stalls, compare against the oldest expectation
  initial begin
    int stall;
    result_t want;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d byte %h", kind, reply_byte);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d actual %0d", want.kind, kind); fail_count++;
        end
        if (slot_bit !== want.slot_bit) begin
          $error("slot_bit: expected %0d actual %0d", want.slot_bit, slot_bit); fail_count++;
        end
        if (reply_byte !== want.reply_byte) begin
          $error("reply_byte: expected %h actual %h", want.reply_byte, reply_byte);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, last); fail_count++;
        end
      end
    end
  end

  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
    logic       s, f, g;
    logic       chk;
    logic [7:0] want;
  } row_t;

  // chk marks rows whose reply byte is typed in
  row_t directed[] = '{
    '{OP_HOST, 8'h0E, 0, 0, 0, 1, 8'h00},  // read entry 7 after reset
    '{OP_HOST, 8'h7E, 0, 0, 0, 1, 8'h7E},  // write entry 7 with 7
    '{OP_HOST, 8'h0E, 0, 0, 0, 1, 8'h0E},  // read it back
    '{OP_HOST, 8'h00, 0, 0, 0, 1, 8'h00},  // entry zero always reads 0
    '{OP_HOST, 8'hFD, 0, 0, 0, 1, 8'hFC},  // pulse reply
    '{OP_HOST, 8'hF1, 0, 0, 0, 0, 8'h00},  // ignored in command mode
    '{OP_HOST, 8'hE3, 0, 0, 0, 0, 8'h00},  // ignored in command mode
    '{OP_HOST, 8'h83, 0, 0, 0, 0, 8'h00},  // single bit write 0, two replies
    '{OP_SLOT, 8'h00, 1, 0, 0, 0, 8'h00},  // zero slot reads back 0
    '{OP_HOST, 8'h93, 0, 0, 0, 0, 8'h00},  // single bit write 1, two replies
    '{OP_HOST, 8'h00, 0, 0, 0, 0, 8'h00},  // dropped while busy
    '{OP_SLOT, 8'h00, 1, 0, 0, 0, 8'h00},
    '{OP_HOST, 8'hC1, 0, 0, 0, 0, 8'h00},  // reset request
    '{OP_SLOT, 8'h00, 1, 0, 0, 0, 8'h00},  // wrong sample, ignored
    '{OP_RST,  8'h00, 0, 1, 1, 1, 8'hCF},
    '{OP_NONE, 8'hFF, 1, 1, 1, 0, 8'h00},  // operation 3 ignored
    '{OP_HOST, 8'h84, 0, 0, 0, 0, 8'h00},  // unknown command code
    '{OP_HOST, 8'hE1, 0, 0, 0, 0, 8'h00},  // to data mode
    '{OP_HOST, 8'hFF, 0, 0, 0, 0, 8'h00},  // data byte
    '{OP_HOST, 8'hE3, 0, 0, 0, 0, 8'h00},  // to check mode
    '{OP_HOST, 8'hE3, 0, 0, 0, 0, 8'h00},  // escaped 0xE3 sent as data
    '{OP_HOST, 8'hE3, 0, 0, 0, 0, 8'h00},  // check mode again
    '{OP_HOST, 8'hB1, 0, 0, 0, 0, 8'h00},  // back to command: search on
    '{OP_HOST, 8'hE1, 0, 0, 0, 0, 8'h00}
  };

  initial begin
    int n, k, pick;
    logic [7:0] c;
    result_t guess;
    rst = 1'b1; push = 1'b0; operation = OP_HOST; host_byte = 0;
    slot_sample = 0; reset_first_sample = 0; reset_second_sample = 0;
    fail_count = 0; beats_sent = 0; results_seen = 0;
    br_mode = ST_CMD; br_search = 0; br_bus = BUS_IDLE; br_held = 0;
    br_slot = 0; br_accum = 0; br_reads = 0;
    foreach (br_params[j]) br_params[j] = 3'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; data bytes get their slots answered right after
    foreach (directed[r]) begin
      send_beat(directed[r].op, directed[r].b, directed[r].s, directed[r].f, directed[r].g);
      if (directed[r].chk) begin
        guess = pending_results[$];
        if (guess.reply_byte !== directed[r].want) begin
          $error("reply_byte: expected %h actual %h", directed[r].want, guess.reply_byte);
          fail_count++;
        end
      end
      if (directed[r].op == OP_HOST && br_bus == BUS_BYTE)
        while (br_bus == BUS_BYTE) answer_bus();
    end
    // a search byte leaves data mode on
    send_beat(OP_HOST, 8'h00, 0, 0, 0);
    while (br_bus != BUS_IDLE) answer_bus();

    // random: mostly well-formed transactions, some noise
    n = 0;
    while (n < 1700) begin
      pick = $urandom_range(0, 9);
      c = 8'($urandom);
      if (pick == 0) begin
        send_beat(2'($urandom), c, 1'($urandom), 1'($urandom), 1'($urandom));
        n++;
      end else if (pick < 4 && br_mode != ST_CMD) begin
        if ($urandom_range(0, 5) == 0) c = CmdCheck;
        send_beat(OP_HOST, c, 0, 0, 0);
        n++;
      end else begin
        if ($urandom_range(0, 6) == 0) c = CmdDataMode;
        else if ($urandom_range(0, 4) == 0) c = {3'b101, 1'($urandom), 4'b0001};
        send_beat(OP_HOST, c, 0, 0, 0);
        n++;
      end
      k = 0;
      while (br_bus != BUS_IDLE && k < 14) begin
        if ($urandom_range(0, 15) == 0)
          send_beat(OP_HOST, 8'($urandom), 0, 0, 0);  // dropped while busy
        else answer_bus();
        n++; k++;
      end
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d input beats and %0d result beats", beats_sent, results_seen);
    $display("search on and off, all modes, bit, reset, pulse and table commands");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
